[rtl/bmm_pkg.sv]
// Shared types and constants of the banked memory mapper.
// No dependencies; the RTL files refer to this package by scoped names, the test files import it.
package bmm_pkg;

  localparam int FLASH_BYTES = 524288;
  localparam int RAM_BYTES   = 65536;
  localparam int PAGE_BYTES  = 16384;

  localparam int FLASH_AW = $clog2(FLASH_BYTES);
  localparam int RAM_AW   = $clog2(RAM_BYTES);
  localparam int OFF_W    = $clog2(PAGE_BYTES);
  localparam int PAGE_W   = 5;
  localparam int LIDX_W   = 19;
  localparam int LEN_W    = 20;
  localparam int ADDR_W   = 16;
  localparam int DATA_W   = 16;
  localparam int OP_W     = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 5;

  localparam logic [OP_W-1:0] OP_READ8  = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE8 = 3'd1;
  localparam logic [OP_W-1:0] OP_READ16 = 3'd2;
  localparam logic [OP_W-1:0] OP_WRITE16 = 3'd3;
  localparam logic [OP_W-1:0] OP_LOAD   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_MAP_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BANK_A_PAGE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BANK_A_IS_RAM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BANK_B_PAGE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BANK_B_IS_RAM = 3'd4;

  localparam logic [7:0] BLANK_BYTE = 8'hFF;

  typedef struct packed {
    logic              map_mode;
    logic [PAGE_W-1:0] bank_a_page;
    logic              bank_a_is_ram;
    logic [PAGE_W-1:0] bank_b_page;
    logic              bank_b_is_ram;
  } cfg_t;

  typedef struct packed {
    logic              is_fixed;
    logic              is_ram;
    logic [PAGE_W-1:0] page;
  } map_t;

  typedef struct packed {
    logic capture;
    logic clear;
    logic access;
    logic byte_hi;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic wide;
    logic clear_last;
  } status_t;

endpackage

[rtl/bmm_ctrl.sv]
// Sequencer of the banked memory mapper: RAM clearing sweep, byte accesses, result.
// Depends on bmm_pkg.
module bmm_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  bmm_pkg::status_t status,
  output logic             busy,
  output bmm_pkg::cmd_t    cmd
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_ACC0  = 3'd2;
  localparam logic [2:0] ST_ACC1  = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       accept;

  assign busy   = (state_r == ST_CLEAR) || (state_r == ST_ACC0) || (state_r == ST_ACC1);
  assign accept = start && !busy;

  assign cmd.capture = accept;
  assign cmd.clear   = (state_r == ST_CLEAR);
  assign cmd.access  = (state_r == ST_ACC0) || (state_r == ST_ACC1);
  assign cmd.byte_hi = (state_r == ST_ACC1);
  assign cmd.finish  = (state_r == ST_FIN);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (status.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE, ST_FIN: begin
        state_nxt = accept ? ST_ACC0 : ST_IDLE;
      end
      ST_ACC0: begin
        state_nxt = status.wide ? ST_ACC1 : ST_FIN;
      end
      ST_ACC1: begin
        state_nxt = ST_FIN;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/bmm_datapath.sv]
// Datapath of the banked memory mapper: item registers, address mapping,
// flash and RAM arrays, loaded length and result assembly. Depends on bmm_pkg.
module bmm_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bmm_pkg::cmd_t                 cmd,
  input  bmm_pkg::cfg_t                 cfg,
  input  logic [bmm_pkg::OP_W-1:0]      in_operation,
  input  logic [bmm_pkg::ADDR_W-1:0]    in_address,
  input  logic [bmm_pkg::DATA_W-1:0]    in_write_data,
  input  logic [bmm_pkg::LIDX_W-1:0]    in_load_index,
  output bmm_pkg::status_t              status,
  output logic [bmm_pkg::DATA_W-1:0]    out_read_data
);

  logic [bmm_pkg::OP_W-1:0]   op_r;
  logic [bmm_pkg::ADDR_W-1:0] addr_r;
  logic [bmm_pkg::DATA_W-1:0] wdata_r;
  logic [bmm_pkg::LIDX_W-1:0] lidx_r;
  logic [bmm_pkg::LEN_W-1:0]  len_r;
  logic [bmm_pkg::RAM_AW-1:0] clr_cnt_r;

  logic [7:0] ram_mem [bmm_pkg::RAM_BYTES];
  logic [7:0] flash_mem [bmm_pkg::FLASH_BYTES];
  logic [7:0] ram_q_r;
  logic [7:0] flash_q_r;
  logic       src_ram_r;
  logic       blank_r;
  logic [7:0] lo_r;

  logic [bmm_pkg::ADDR_W-1:0] byte_addr;
  bmm_pkg::map_t              map;
  logic [bmm_pkg::LIDX_W-1:0] map_fidx;
  logic [bmm_pkg::RAM_AW-1:0] map_ridx;
  logic                       is_load;
  logic                       is_write;
  logic                       load_ok;
  logic                       ram_we;
  logic [bmm_pkg::RAM_AW-1:0] ram_addr;
  logic [7:0]                 ram_wdata;
  logic                       flash_we;
  logic [bmm_pkg::LIDX_W-1:0] flash_addr;
  logic [7:0]                 wbyte;
  logic [7:0]                 byte_val;

  function automatic bmm_pkg::map_t map_addr(input logic [bmm_pkg::ADDR_W-1:0] a,
                                             input bmm_pkg::cfg_t c);
    bmm_pkg::map_t m;
    m.is_fixed = (a[15:14] == 2'b00);
    m.is_ram   = 1'b0;
    m.page     = '0;
    case (a[15:14])
      2'b01: begin
        m.is_ram = c.bank_a_is_ram;
        m.page   = c.map_mode ? {c.bank_a_page[bmm_pkg::PAGE_W-1:1], 1'b0} : c.bank_a_page;
      end
      2'b10: begin
        m.is_ram = c.map_mode ? c.bank_a_is_ram : c.bank_b_is_ram;
        m.page   = c.map_mode ? c.bank_a_page : c.bank_b_page;
      end
      2'b11: begin
        m.is_ram = c.map_mode ? c.bank_b_is_ram : 1'b1;
        m.page   = c.map_mode ? c.bank_b_page : '0;
      end
      default: begin
        m.is_ram = 1'b0;
        m.page   = '0;
      end
    endcase
    return m;
  endfunction

  assign byte_addr = cmd.byte_hi ? bmm_pkg::ADDR_W'(addr_r + 16'd1) : addr_r;
  assign map       = map_addr(byte_addr, cfg);
  assign map_fidx  = {map.page, byte_addr[bmm_pkg::OFF_W-1:0]};
  assign map_ridx  = {map.page[1:0], byte_addr[bmm_pkg::OFF_W-1:0]};
  assign wbyte     = cmd.byte_hi ? wdata_r[15:8] : wdata_r[7:0];

  assign is_load  = (op_r == bmm_pkg::OP_LOAD);
  assign is_write = (op_r == bmm_pkg::OP_WRITE8) || (op_r == bmm_pkg::OP_WRITE16);
  assign load_ok  = ({1'b0, lidx_r} < bmm_pkg::LEN_W'(bmm_pkg::FLASH_BYTES));

  assign status.wide = (op_r == bmm_pkg::OP_READ16) || (op_r == bmm_pkg::OP_WRITE16);
  assign status.clear_last = (clr_cnt_r == '1);

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = map_ridx;
    ram_wdata = wbyte;
    if (cmd.clear) begin
      ram_we    = 1'b1;
      ram_addr  = clr_cnt_r;
      ram_wdata = 8'h00;
    end else if (cmd.access && is_load) begin
      ram_we    = load_ok && (lidx_r[bmm_pkg::LIDX_W-1:bmm_pkg::OFF_W] == '0);
      ram_addr  = bmm_pkg::RAM_AW'(lidx_r[bmm_pkg::OFF_W-1:0]);
      ram_wdata = wdata_r[7:0];
    end else if (cmd.access && is_write) begin
      ram_we = !map.is_fixed && map.is_ram;
    end
  end

  assign flash_we   = cmd.access && is_load && load_ok;
  assign flash_addr = is_load ? lidx_r : map_fidx;

  always_ff @(posedge clk) begin
    if (ram_we) ram_mem[ram_addr] <= ram_wdata;
    ram_q_r <= ram_mem[ram_addr];
  end

  always_ff @(posedge clk) begin
    if (flash_we) flash_mem[flash_addr[bmm_pkg::FLASH_AW-1:0]] <= wdata_r[7:0];
    flash_q_r <= flash_mem[flash_addr[bmm_pkg::FLASH_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_operation;
      addr_r  <= in_address;
      wdata_r <= in_write_data;
      lidx_r  <= in_load_index;
    end
    if (cmd.access) begin
      src_ram_r <= !map.is_fixed && map.is_ram;
      blank_r   <= ({1'b0, map_fidx} >= len_r);
    end
    if (cmd.byte_hi) lo_r <= byte_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= '0;
      clr_cnt_r <= '0;
    end else begin
      if (flash_we) len_r <= {1'b0, lidx_r} + bmm_pkg::LEN_W'(1);
      if (cmd.clear) clr_cnt_r <= bmm_pkg::RAM_AW'(clr_cnt_r + 1'b1);
    end
  end

  assign byte_val = src_ram_r ? ram_q_r : (blank_r ? bmm_pkg::BLANK_BYTE : flash_q_r);

  always_comb begin
    case (op_r)
      bmm_pkg::OP_READ8:  out_read_data = {8'h00, byte_val};
      bmm_pkg::OP_READ16: out_read_data = {byte_val, lo_r};
      default:            out_read_data = '0;
    endcase
  end

endmodule

[rtl/banked_memory_mapper_core.sv]
// Top level of the banked memory mapper: configuration registers, sequencer
// and datapath. Depends on bmm_pkg, bmm_ctrl and bmm_datapath.
//
//  channel  handshake            payload
//  input    start / busy         in_operation, in_address, in_write_data, in_load_index
//  result   out_valid (strobe)   out_read_data
//  config   cfg_wr_en            cfg_index, cfg_wr_data
//
// Each beat makes a registered access to the byte-wide RAM or flash array for each
// of its bytes, then shows the result on the ports in the finish state, during
// which the next beat is taken.
// After reset a clearing sweep writes zero to all 65536 RAM bytes, one per
// cycle, with busy high; configuration writes are taken during it.
// The receiver cannot stall: out_valid stands for exactly one cycle.
module banked_memory_mapper_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [bmm_pkg::OP_W-1:0]         in_operation,
  input  logic [bmm_pkg::ADDR_W-1:0]       in_address,
  input  logic [bmm_pkg::DATA_W-1:0]       in_write_data,
  input  logic [bmm_pkg::LIDX_W-1:0]       in_load_index,
  output logic                             out_valid,
  output logic [bmm_pkg::DATA_W-1:0]       out_read_data,
  input  logic                             cfg_wr_en,
  input  logic [bmm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bmm_pkg::CFG_DAT_W-1:0]    cfg_wr_data
);

  bmm_pkg::cfg_t    cfg_r;
  bmm_pkg::cmd_t    cmd;
  bmm_pkg::status_t status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bmm_pkg::CFG_MAP_MODE:      cfg_r.map_mode      <= cfg_wr_data[0];
        bmm_pkg::CFG_BANK_A_PAGE:   cfg_r.bank_a_page   <= cfg_wr_data;
        bmm_pkg::CFG_BANK_A_IS_RAM: cfg_r.bank_a_is_ram <= cfg_wr_data[0];
        bmm_pkg::CFG_BANK_B_PAGE:   cfg_r.bank_b_page   <= cfg_wr_data;
        bmm_pkg::CFG_BANK_B_IS_RAM: cfg_r.bank_b_is_ram <= cfg_wr_data[0];
        default: begin
        end
      endcase
    end
  end

  bmm_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  bmm_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .cfg           (cfg_r),
    .in_operation  (in_operation),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .in_load_index (in_load_index),
    .status        (status),
    .out_read_data (out_read_data)
  );

  assign out_valid = cmd.finish;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (busy && !out_valid))
    else $error("RAM clearing sweep not started after reset");

endmodule

[test/bmm_access_checker.sv]
// Checker for banked_memory_mapper_core: watches the command, result and register ports,
// keeps its own image of the memory map and compares every read_data beat.
// Depends on bmm_pkg for widths, operation codes and register indexes.
module bmm_access_checker
  import bmm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic [OP_W-1:0]      in_operation,
  input  logic [ADDR_W-1:0]    in_address,
  input  logic [DATA_W-1:0]    in_write_data,
  input  logic [LIDX_W-1:0]    in_load_index,
  input  logic                 out_valid,
  input  logic [DATA_W-1:0]    out_read_data,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wr_data,
  output int                   mismatch_count,
  output int                   reads_due
);

  typedef struct packed {
    logic              is_ram;
    logic [PAGE_W-1:0] page;
  } window_t;

  bit   [7:0]        ram_img [RAM_BYTES];
  bit   [7:0]        flash_img [bit [LIDX_W-1:0]];
  bit   [LEN_W-1:0]  loaded_len;
  cfg_t              regs;
  logic [DATA_W-1:0] due_q [$];
  int                errors;

  function automatic window_t window_of(input logic [ADDR_W-1:0] addr);
    window_t w;
    w.is_ram = 1'b0;
    w.page   = '0;
    if (addr < 16'h4000) return w;
    if (!regs.map_mode) begin
      if (addr < 16'h8000) begin
        w.page   = regs.bank_a_page;
        w.is_ram = regs.bank_a_is_ram;
      end else if (addr < 16'hC000) begin
        w.page   = regs.bank_b_page;
        w.is_ram = regs.bank_b_is_ram;
      end else begin
        w.page   = '0;
        w.is_ram = 1'b1;
      end
    end else begin
      if (addr < 16'h8000) begin
        w.page   = {regs.bank_a_page[PAGE_W-1:1], 1'b0};
        w.is_ram = regs.bank_a_is_ram;
      end else if (addr < 16'hC000) begin
        w.page   = regs.bank_a_page;
        w.is_ram = regs.bank_a_is_ram;
      end else begin
        w.page   = regs.bank_b_page;
        w.is_ram = regs.bank_b_is_ram;
      end
    end
    return w;
  endfunction

  function automatic logic [7:0] read_byte(input logic [ADDR_W-1:0] addr);
    window_t           w;
    logic [LIDX_W-1:0] idx;
    w = window_of(addr);
    if (w.is_ram) return ram_img[{w.page[1:0], addr[OFF_W-1:0]}];
    idx = {w.page, addr[OFF_W-1:0]};
    if ({1'b0, idx} >= loaded_len) return BLANK_BYTE;
    return flash_img.exists(idx) ? flash_img[idx] : 8'h00;
  endfunction

  function automatic void write_byte(input logic [ADDR_W-1:0] addr, input logic [7:0] value);
    window_t w;
    w = window_of(addr);
    if (w.is_ram) ram_img[{w.page[1:0], addr[OFF_W-1:0]}] = value;
  endfunction

  function automatic logic [DATA_W-1:0] predict_access(
    input logic [OP_W-1:0]   op,
    input logic [ADDR_W-1:0] addr,
    input logic [DATA_W-1:0] wdata,
    input logic [LIDX_W-1:0] lidx
  );
    logic [DATA_W-1:0] result;
    result = '0;
    case (op)
      OP_READ8:   result = {8'h00, read_byte(addr)};
      OP_WRITE8:  write_byte(addr, wdata[7:0]);
      OP_READ16:  result = {read_byte(addr + 16'd1), read_byte(addr)};
      OP_WRITE16: begin
        write_byte(addr, wdata[7:0]);
        write_byte(addr + 16'd1, wdata[15:8]);
      end
      OP_LOAD: begin
        if (int'(lidx) < FLASH_BYTES) begin
          flash_img[lidx] = wdata[7:0];
          loaded_len = {1'b0, lidx} + 20'd1;
          if (int'(lidx) < PAGE_BYTES) ram_img[lidx[RAM_AW-1:0]] = wdata[7:0];
        end
      end
      default: ;
    endcase
    return result;
  endfunction

  always @(posedge clk) begin
    logic [DATA_W-1:0] expected;
    if (!rst_n) begin
      foreach (ram_img[i]) ram_img[i] = 8'h00;
      flash_img.delete();
      loaded_len = '0;
      regs = '0;
      due_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_MAP_MODE:      regs.map_mode      = cfg_wr_data[0];
          CFG_BANK_A_PAGE:   regs.bank_a_page   = cfg_wr_data[PAGE_W-1:0];
          CFG_BANK_A_IS_RAM: regs.bank_a_is_ram = cfg_wr_data[0];
          CFG_BANK_B_PAGE:   regs.bank_b_page   = cfg_wr_data[PAGE_W-1:0];
          CFG_BANK_B_IS_RAM: regs.bank_b_is_ram = cfg_wr_data[0];
          default: ;
        endcase
      end
      if (out_valid) begin
        if (due_q.size() == 0) begin
          $error("read_data: expected none, actual %h", out_read_data);
          errors++;
        end else begin
          expected = due_q.pop_front();
          if (out_read_data !== expected) begin
            $error("read_data: expected %h, actual %h", expected, out_read_data);
            errors++;
          end
        end
      end
      if (start && !busy)
        due_q.push_back(predict_access(in_operation, in_address, in_write_data, in_load_index));
    end
    mismatch_count <= errors;
    reads_due      <= due_q.size();
  end

endmodule

[test/tb_banked_memory_mapper_core.sv]
// Top of the banked_memory_mapper_core bench: clock, reset, register setup and command beats.
// Depends on bmm_pkg, the block and bmm_access_checker, which predicts and compares.
module tb_banked_memory_mapper_core;
  import bmm_pkg::*;

  localparam int QUIET_LIMIT = 200000;
  localparam int PHASE_BEATS = 190;
  localparam logic [OP_W-1:0] OP_SPARE_LO = OP_LOAD + 3'd1;
  localparam logic [OP_W-1:0] OP_SPARE_HI = '1;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [OP_W-1:0]      in_operation;
  logic [ADDR_W-1:0]    in_address;
  logic [DATA_W-1:0]    in_write_data;
  logic [LIDX_W-1:0]    in_load_index;
  logic                 out_valid;
  logic [DATA_W-1:0]    out_read_data;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_wr_data;

  int                mismatch_count;
  int                reads_due;
  int                quiet_cycles;
  int                sender_idle_pct;
  int                flash_filled;
  logic [ADDR_W-1:0] last_write_address;

  banked_memory_mapper_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_operation  (in_operation),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .in_load_index (in_load_index),
    .out_valid     (out_valid),
    .out_read_data (out_read_data),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wr_data   (cfg_wr_data)
  );

  bmm_access_checker access_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_address     (in_address),
    .in_write_data  (in_write_data),
    .in_load_index  (in_load_index),
    .out_valid      (out_valid),
    .out_read_data  (out_read_data),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wr_data    (cfg_wr_data),
    .mismatch_count (mismatch_count),
    .reads_due      (reads_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  task automatic send_beat(
    input logic [OP_W-1:0]   op,
    input logic [ADDR_W-1:0] addr,
    input logic [DATA_W-1:0] wdata,
    input logic [LIDX_W-1:0] lidx
  );
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_operation  <= op;
    in_address    <= addr;
    in_write_data <= wdata;
    in_load_index <= lidx;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_load(input logic [LIDX_W-1:0] lidx, input logic [DATA_W-1:0] wdata);
    if (int'(lidx) == flash_filled) flash_filled++;
    send_beat(OP_LOAD, 16'($urandom), wdata, lidx);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= value;
    @(posedge clk);
  endtask

  // pad one-bit registers with random upper bits
  task automatic write_regs(input cfg_t c);
    put_reg(CFG_MAP_MODE,      {4'($urandom), c.map_mode});
    put_reg(CFG_BANK_A_PAGE,   c.bank_a_page);
    put_reg(CFG_BANK_A_IS_RAM, {4'($urandom), c.bank_a_is_ram});
    put_reg(CFG_BANK_B_PAGE,   c.bank_b_page);
    put_reg(CFG_BANK_B_IS_RAM, {4'($urandom), c.bank_b_is_ram});
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_for_quiet();
    start <= 1'b0;
    @(posedge clk);
    while (reads_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [ADDR_W-1:0] pick_address();
    logic [ADDR_W-1:0] a;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: a = 16'($urandom);
      4, 5, 6:    a = {2'($urandom), 5'd0, 9'($urandom)};
      7:          a = {2'($urandom), ($urandom_range(0, 1) != 0) ? 14'h3FFF : 14'h0000};
      default:    a = last_write_address + 16'($urandom_range(0, 1));
    endcase
    return a;
  endfunction

  function automatic cfg_t pick_config();
    cfg_t c;
    c.map_mode      = 1'($urandom);
    c.bank_a_page   = ($urandom_range(0, 1) != 0) ? 5'($urandom_range(0, 3)) : 5'($urandom);
    c.bank_a_is_ram = 1'($urandom);
    c.bank_b_page   = ($urandom_range(0, 1) != 0) ? 5'($urandom_range(0, 3)) : 5'($urandom);
    c.bank_b_is_ram = 1'($urandom);
    return c;
  endfunction

  task automatic random_beat();
    int                pick;
    int                lidx;
    logic [ADDR_W-1:0] addr;
    pick = $urandom_range(0, 99);
    addr = pick_address();
    if (pick < 25) begin
      send_beat(OP_READ8, addr, 16'($urandom), 19'($urandom));
    end else if (pick < 45) begin
      send_beat(OP_READ16, addr, 16'($urandom), 19'($urandom));
    end else if (pick < 65) begin
      last_write_address = addr;
      send_beat(OP_WRITE8, addr, 16'($urandom), 19'($urandom));
    end else if (pick < 83) begin
      last_write_address = addr;
      send_beat(OP_WRITE16, addr, 16'($urandom), 19'($urandom));
    end else if (pick < 97) begin
      // only append or rewrite, so every byte below the loaded length stays written
      lidx = ($urandom_range(0, 3) != 0) ? flash_filled : $urandom_range(flash_filled, 0);
      send_load(19'(lidx), 16'($urandom));
    end else begin
      send_beat(3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO)), addr, 16'($urandom),
                19'($urandom));
    end
  endtask

  initial begin
    cfg_t setting;
    rst_n              <= 1'b0;
    start              <= 1'b0;
    in_operation       <= '0;
    in_address         <= '0;
    in_write_data      <= '0;
    in_load_index      <= '0;
    cfg_wr_en          <= 1'b0;
    cfg_index          <= '0;
    cfg_wr_data        <= '0;
    sender_idle_pct    = 25;
    flash_filled       = 0;
    last_write_address = 16'hC000;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    setting               = '0;
    setting.bank_b_page   = 5'd5;
    setting.bank_b_is_ram = 1'b1;
    write_regs(setting);

    send_load(19'd0, 16'h5A00);
    send_load(19'd1, 16'h12FF);
    send_load(19'd2, 16'hFFA5);
    send_load(19'd3, 16'h005A);
    send_load(19'd4, 16'h8001);
    send_load(19'd5, 16'h7F80);
    send_beat(OP_READ8,   16'h0000, 16'h0000, 19'h7FFFF);
    send_beat(OP_READ8,   16'h0005, 16'hFFFF, 19'h00000);
    send_beat(OP_READ8,   16'h0006, 16'h0000, 19'h7FFFF);
    send_beat(OP_READ16,  16'hFFFF, 16'h0000, 19'h00000);
    send_beat(OP_WRITE8,  16'h0001, 16'hFFFF, 19'h00000);
    send_beat(OP_READ8,   16'h0001, 16'h0000, 19'h00000);
    send_beat(OP_WRITE16, 16'h7FFF, 16'hBEEF, 19'h7FFFF);
    send_beat(OP_READ16,  16'h7FFF, 16'h0000, 19'h00000);
    send_beat(OP_WRITE16, 16'hFFFF, 16'hFFFF, 19'h00000);
    send_beat(OP_READ16,  16'hFFFF, 16'h0000, 19'h00000);
    send_beat(OP_WRITE8,  16'hC002, 16'h0000, 19'h00000);
    send_beat(OP_READ8,   16'hC002, 16'h0000, 19'h00000);
    send_load(19'd2, 16'h003C);
    send_beat(OP_READ8,   16'h0004, 16'h0000, 19'h00000);
    send_beat(OP_READ8,   16'h0002, 16'h0000, 19'h00000);
    for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++)
      send_beat(3'(op), 16'hFFFF, 16'hFFFF, 19'h7FFFF);
    send_beat(OP_READ16,  16'h3FFF, 16'h0000, 19'h00000);

    for (int p = 0; p < 6; p++) begin
      wait_for_quiet();
      sender_idle_pct = (p < 2) ? 25 : (p < 4) ? 74 : 0;
      if (p == 0) setting = '0;
      else if (p == 3) setting = '1;
      else setting = pick_config();
      write_regs(setting);
      repeat (PHASE_BEATS) random_beat();
    end

    wait_for_quiet();
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
